>>> hw/rtl/sip24_pkg.sv
`default_nettype none

package sip24_pkg;

  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [63:0] SIP_FINAL_XOR = 64'h00000000000000ff;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned TAIL_W = 3;
  localparam int unsigned IN_TDATA_W = 72;
  localparam int unsigned CFG_INDEX_W = 1;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 1'b1;

  localparam logic [1:0] FINAL_ROUNDS_LAST = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_FINAL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } lanes_t;

  // controller -> datapath
  typedef struct packed {
    logic start_item;   // beat accepted: build block, first round
    logic absorb_end;   // second round, fold the block into lane a
    logic final_round;  // one finalization round
    logic load_hash;    // move the hash into the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic item_last;
  } dp_status_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned s);
    rotl64 = (x << s) | (x >> (64 - s));
  endfunction

  function automatic lanes_t sip_round(input lanes_t l);
    lanes_t r;
    r = l;
    r.a = r.a + r.b;
    r.b = rotl64(r.b, 13) ^ r.a;
    r.a = rotl64(r.a, 32);
    r.c = r.c + r.d;
    r.d = rotl64(r.d, 16) ^ r.c;
    r.a = r.a + r.d;
    r.d = rotl64(r.d, 21) ^ r.a;
    r.c = r.c + r.b;
    r.b = rotl64(r.b, 17) ^ r.c;
    r.c = rotl64(r.c, 32);
    sip_round = r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sip24_ctrl.sv
`default_nettype none

module sip24_ctrl
  import sip24_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t     state;
  state_t     state_next;
  logic [1:0] fin_count;
  logic [1:0] fin_count_next;
  logic       out_valid_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    fin_count_next = fin_count;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_ABSORB;
        end
      end
      ST_ABSORB: begin
        fin_count_next = '0;
        state_next = status.item_last ? ST_FINAL : ST_IDLE;
      end
      ST_FINAL: begin
        fin_count_next = fin_count + 2'd1;
        if (fin_count == FINAL_ROUNDS_LAST) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.start_item = in_valid;
      end
      ST_ABSORB: cmd.absorb_end = 1'b1;
      ST_FINAL:  cmd.final_round = 1'b1;
      ST_EMIT:   cmd.load_hash = slot_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // hold the result until the sink takes it
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_hash) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fin_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fin_count <= fin_count_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sip24_datapath.sv
`default_nettype none

module sip24_datapath
  import sip24_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]      cfg_data,
  input  wire logic [WORD_W-1:0]      data_word,
  input  wire logic [TAIL_W-1:0]      tail_bytes,
  input  wire logic                   last,
  input  wire dp_cmd_t                cmd,
  output dp_status_t                  status,
  output logic [WORD_W-1:0]           hash_value
);

  logic [63:0] key_low;
  logic [63:0] key_high;
  lanes_t      lanes;
  lanes_t      lanes_next;
  lanes_t      round_in;
  lanes_t      round_out;
  logic [63:0] block;
  logic [63:0] block_next;
  logic [63:0] tail_word;
  logic [7:0]  byte_total;
  logic [7:0]  total_base;
  logic [7:0]  total_sum;
  logic        in_message;
  logic        item_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= '0;
      key_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_LOW:  key_low <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        default: begin
          key_low <= key_low;
        end
      endcase
    end
  end

  // drop bytes at or above the tail count
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      tail_word[8*i +: 8] = (i < int'(tail_bytes)) ? data_word[8*i +: 8] : 8'h00;
    end
  end

  assign total_base = in_message ? byte_total : 8'd0;
  assign total_sum = total_base + (last ? {5'd0, tail_bytes} : 8'd8);
  assign block_next = last ? {total_sum, tail_word[55:0]} : data_word;

  // a new message starts from the key, then the block goes into lane d
  always_comb begin
    round_in = lanes;
    if (cmd.start_item) begin
      if (!in_message) begin
        round_in.a = SIP_C0 ^ key_low;
        round_in.b = SIP_C1 ^ key_high;
        round_in.c = SIP_C2 ^ key_low;
        round_in.d = SIP_C3 ^ key_high;
      end
      round_in.d = round_in.d ^ block_next;
    end
  end

  assign round_out = sip_round(round_in);

  always_comb begin
    lanes_next = round_out;
    if (cmd.absorb_end) begin
      lanes_next.a = round_out.a ^ block;
      if (item_last) begin
        lanes_next.c = round_out.c ^ SIP_FINAL_XOR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_item || cmd.absorb_end || cmd.final_round) begin
      lanes <= lanes_next;
    end
    if (cmd.start_item) begin
      block <= block_next;
    end
    if (cmd.load_hash) begin
      hash_value <= lanes.a ^ lanes.b ^ lanes.c ^ lanes.d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_total <= '0;
      in_message <= 1'b0;
      item_last <= 1'b0;
    end else if (cmd.start_item) begin
      byte_total <= last ? 8'd0 : total_sum;
      in_message <= !last;
      item_last <= last;
    end
  end

  assign status.item_last = item_last;

endmodule

`default_nettype wire

>>> hw/rtl/siphash_2_4_engine_core.sv
// Channel   Dir  Signals                                Content
// s_axis    in   tvalid tready tdata[71:0] tlast       message words, tlast closes message
// m_axis    out  tvalid tready tdata[63:0]             one hash per message
// cfg       in   cfg_we cfg_index cfg_data[63:0]       key_low (0), key_high (1)
//
// One shared SipRound unit does one round per cycle. For a full word, ready drops
// in the cycle after the beat, then returns. The closing beat runs 2 compression
// rounds and 4 finalization rounds, then loads the hash. The hash sits in an output
// register; the next message is taken while it waits, and only the final load stalls
// until the register is free. Reset (rst, synchronous) clears the key, the byte count
// and the open-message flag.
`default_nettype none

module siphash_2_4_engine_core
  import sip24_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // data_word[63:0], tail_bytes[66:64]
  input  wire logic                   s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [WORD_W-1:0]           m_axis_tdata,  // hash_value[63:0]
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]      cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sip24_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  sip24_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .data_word  (s_axis_tdata[63:0]),
    .tail_bytes (s_axis_tdata[66:64]),
    .last       (s_axis_tlast),
    .cmd        (cmd),
    .status     (status),
    .hash_value (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> tb/siphash_2_4_engine_core_test.sv
`timescale 1ns / 100ps

class hash_scoreboard;
  logic [63:0] key0;
  logic [63:0] key1;
  logic [63:0] va;
  logic [63:0] vb;
  logic [63:0] vc;
  logic [63:0] vd;
  logic [7:0]  length_mod;
  bit          open_msg;
  logic [63:0] hash_q[$];
  int          errors;

  function new();
    key0 = '0;
    key1 = '0;
    va = '0;
    vb = '0;
    vc = '0;
    vd = '0;
    length_mod = '0;
    open_msg = 1'b0;
    errors = 0;
  endfunction

  function void set_key(input logic [sip24_pkg::CFG_INDEX_W-1:0] idx, input logic [63:0] value);
    if (idx == sip24_pkg::REG_KEY_LOW) key0 = value;
    else if (idx == sip24_pkg::REG_KEY_HIGH) key1 = value;
  endfunction

  function void mix_round();
    va = va + vb;
    vb = {vb[50:0], vb[63:51]} ^ va;
    va = {va[31:0], va[63:32]};
    vc = vc + vd;
    vd = {vd[47:0], vd[63:48]} ^ vc;
    va = va + vd;
    vd = {vd[42:0], vd[63:43]} ^ va;
    vc = vc + vb;
    vb = {vb[46:0], vb[63:47]} ^ vc;
    vc = {vc[31:0], vc[63:32]};
  endfunction

  function void fold_block(input logic [63:0] m);
    vd = vd ^ m;
    mix_round();
    mix_round();
    va = va ^ m;
  endfunction

  // one accepted input beat; a closing beat queues the expected hash
  function void note_beat(input logic [63:0] word, input logic [2:0] tail, input bit last);
    logic [63:0] block;
    if (!open_msg) begin
      va = sip24_pkg::SIP_C0 ^ key0;
      vb = sip24_pkg::SIP_C1 ^ key1;
      vc = sip24_pkg::SIP_C2 ^ key0;
      vd = sip24_pkg::SIP_C3 ^ key1;
      length_mod = '0;
      open_msg = 1'b1;
    end
    if (!last) begin
      fold_block(word);
      length_mod = length_mod + 8'd8;
    end else begin
      length_mod = length_mod + {5'b0, tail};
      block = word & ((64'd1 << (8 * tail)) - 64'd1);
      block[63:56] = length_mod;
      fold_block(block);
      vc = vc ^ sip24_pkg::SIP_FINAL_XOR;
      repeat (4) mix_round();
      hash_q.push_back(va ^ vb ^ vc ^ vd);
      open_msg = 1'b0;
      length_mod = '0;
    end
  endfunction

  function void check_hash(input logic [63:0] got);
    logic [63:0] want;
    if (hash_q.size() == 0) begin
      $error("hash_value: expected none, actual %h", got);
      errors++;
    end else begin
      want = hash_q.pop_front();
      if (want !== got) begin
        $error("hash_value: expected %h, actual %h", want, got);
        errors++;
      end
    end
  endfunction
endclass

module siphash_2_4_engine_core_test;
  import sip24_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int BLOCK_ITEMS = 145;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;  // data_word[63:0], tail_bytes[66:64]
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [WORD_W-1:0]      m_axis_tdata;  // hash_value[63:0]
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [WORD_W-1:0]      cfg_data;

  hash_scoreboard sb;
  int  send_idle;
  int  recv_idle;
  bit  hold_out;
  int  quiet_cycles;

  siphash_2_4_engine_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_axis_tready <= !hold_out && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_hash(m_axis_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand_word();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) rand_word = '0;
    else if (pick < 3) rand_word = '1;
    else rand_word = {$urandom, $urandom};
  endfunction

  task automatic send_beat(input logic [63:0] word, input logic [2:0] tail, input bit last);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, tail, word};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_beat(word, tail, last);
    @(negedge clk);
  endtask

  // wait for the engine to drain, then load both key halves
  task automatic load_key(input logic [63:0] k0, input logic [63:0] k1);
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.hash_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEY_LOW;
    cfg_data  <= k0;
    @(negedge clk);
    cfg_index <= REG_KEY_HIGH;
    cfg_data  <= k1;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_key(REG_KEY_LOW, k0);
    sb.set_key(REG_KEY_HIGH, k1);
  endtask

  task automatic load_random_key();
    int pick;
    pick = $urandom_range(3);
    if (pick == 0) load_key('0, '0);
    else if (pick == 1) load_key('1, '1);
    else load_key(rand_word(), rand_word());
  endtask

  task automatic run_block(input int n_items);
    int count;
    int pick;
    int n_full;
    count = 0;
    while (count < n_items) begin
      pick = $urandom_range(99);
      // some messages pass 256 bytes so the length byte wraps
      if (pick < 8) n_full = 32 + $urandom_range(8);
      else if (pick < 25) n_full = $urandom_range(20, 7);
      else n_full = $urandom_range(4);
      for (int i = 0; i < n_full; i++) send_beat(rand_word(), 3'($urandom_range(7)), 1'b0);
      send_beat(rand_word(), 3'($urandom_range(7)), 1'b1);
      count += n_full + 1;
    end
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_KEY_LOW;
    cfg_data = '0;
    hold_out = 1'b0;
    quiet_cycles = 0;
    send_idle = 24;
    recv_idle = 61;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // directed: empty message, masking, ignored tail on full words, key extremes
    load_key('0, '0);
    send_beat('1, 3'd0, 1'b1);
    load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
    send_beat(64'h0706050403020100, 3'd0, 1'b0);
    send_beat(64'hff0e0d0c0b0a0908, 3'd7, 1'b1);
    for (int t = 1; t < 8; t++) send_beat('1, 3'(t), 1'b1);
    send_beat('1, 3'd7, 1'b0);
    send_beat('1, 3'd5, 1'b0);
    send_beat('1, 3'd0, 1'b1);
    send_beat('0, 3'd0, 1'b0);
    send_beat('0, 3'd7, 1'b1);
    load_key('1, '1);
    send_beat('1, 3'd4, 1'b0);
    send_beat('1, 3'd3, 1'b1);

    for (int b = 0; b < 3; b++) begin
      load_random_key();
      run_block(BLOCK_ITEMS);
    end

    send_idle = 61;
    recv_idle = 24;
    for (int b = 0; b < 3; b++) begin
      load_random_key();
      run_block(BLOCK_ITEMS);
    end

    send_idle = 0;
    recv_idle = 0;
    load_key(rand_word(), rand_word());
    // stall the hash output long enough to back up the input
    fork
      run_block(BLOCK_ITEMS);
      begin
        repeat (40) @(negedge clk);
        hold_out = 1'b1;
        repeat (300) @(negedge clk);
        hold_out = 1'b0;
      end
    join
    for (int b = 0; b < 2; b++) begin
      load_random_key();
      run_block(BLOCK_ITEMS);
    end

    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.hash_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.hash_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
